/* hdl/srlp_pkg.sv */
// Shared types and constants for the style run list parser.
package srlp_pkg;

  localparam logic [7:0] CH_SEMI  = 8'h3B;  // ';'
  localparam logic [7:0] CH_DASH  = 8'h2D;  // '-'
  localparam logic [7:0] CH_COLON = 8'h3A;  // ':'
  localparam logic [7:0] CH_HASH  = 8'h23;  // '#'
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_LA    = 8'h61;  // 'a'
  localparam logic [7:0] CH_LF    = 8'h66;  // 'f'
  localparam logic [7:0] CH_UA    = 8'h41;  // 'A'
  localparam logic [7:0] CH_UF    = 8'h46;  // 'F'
  localparam logic [7:0] CH_LB    = 8'h62;  // 'b'
  localparam logic [7:0] CH_UB    = 8'h42;  // 'B'
  localparam logic [7:0] CH_LI    = 8'h69;  // 'i'
  localparam logic [7:0] CH_UI    = 8'h49;  // 'I'
  localparam logic [7:0] CH_LC    = 8'h63;  // 'c'

  localparam int unsigned HEX_DIGITS = 8;

  localparam logic [1:0] STATUS_MORE     = 2'd0;
  localparam logic [1:0] STATUS_ACCEPTED = 2'd1;
  localparam logic [1:0] STATUS_REJECTED = 2'd2;

  typedef struct packed {
    logic [1:0]  status;
    logic        run_valid;
    logic [31:0] run_first;
    logic [31:0] run_limit;
    logic        has_weight;
    logic        weight_bold;
    logic        has_slant;
    logic        slant_italic;
    logic        has_color;
    logic [31:0] color_argb;
  } srlp_result_t;

endpackage

/* hdl/srlp_core.sv */
// Parser state and per-byte step logic: one byte in, at most one result out.
module srlp_core #(
  parameter int OFFSET_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [7:0]           item_byte,
  input  logic                 item_no_byte,
  input  logic                 item_last,
  input  logic                 take,
  output logic                 emit,
  output srlp_pkg::srlp_result_t result
);
  import srlp_pkg::*;

  typedef enum logic [2:0] {
    PH_START, PH_END, PH_FLAGS, PH_HASH, PH_HEX
  } phase_t;

  localparam int SB_HAS_WEIGHT = 0;
  localparam int SB_BOLD       = 1;
  localparam int SB_HAS_SLANT  = 2;
  localparam int SB_ITALIC     = 3;
  localparam int SB_HAS_COLOR  = 4;

  phase_t                 phase, phase_next;
  logic [OFFSET_BITS-1:0] start_accum, start_accum_next;
  logic [OFFSET_BITS-1:0] end_accum, end_accum_next;
  logic                   digit_seen, digit_seen_next;
  logic [OFFSET_BITS-1:0] previous_limit, previous_limit_next;
  logic                   have_previous, have_previous_next;
  logic [4:0]             style_bits, style_bits_next;
  logic [31:0]            hex_accum, hex_accum_next;
  logic [3:0]             hex_count, hex_count_next;
  logic                   rejected, rejected_next;
  logic                   bytes_seen, bytes_seen_next;

  // Decimal step: acc * 10 + d, with four spare bits to catch overflow.
  function automatic logic [OFFSET_BITS+3:0] mul10_add(input logic [OFFSET_BITS-1:0] acc,
                                                      input logic [3:0] d);
    logic [OFFSET_BITS+3:0] wide;
    wide = {4'd0, acc};
    return (wide << 3) + (wide << 1) + {{OFFSET_BITS{1'b0}}, d};
  endfunction

  function automatic logic [31:0] to32(input logic [OFFSET_BITS-1:0] v);
    logic [OFFSET_BITS+31:0] ext;
    ext = {32'd0, v};
    return ext[31:0];
  endfunction

  function automatic logic close_ok(input phase_t ph, input logic [3:0] cnt,
                                    input logic [4:0] sb);
    return ((ph == PH_FLAGS) || (ph == PH_HEX && cnt == 4'(HEX_DIGITS))) && (sb != 5'd0);
  endfunction

  function automatic srlp_result_t make_run(input logic [1:0] st,
                                            input logic [OFFSET_BITS-1:0] first,
                                            input logic [OFFSET_BITS-1:0] limit,
                                            input logic [4:0] sb,
                                            input logic [31:0] hex);
    srlp_result_t r;
    r.status       = st;
    r.run_valid    = 1'b1;
    r.run_first    = to32(first);
    r.run_limit    = to32(limit);
    r.has_weight   = sb[SB_HAS_WEIGHT];
    r.weight_bold  = sb[SB_BOLD];
    r.has_slant    = sb[SB_HAS_SLANT];
    r.slant_italic = sb[SB_ITALIC];
    r.has_color    = sb[SB_HAS_COLOR];
    r.color_argb   = sb[SB_HAS_COLOR] ? {hex[7:0], hex[31:8]} : 32'd0;
    return r;
  endfunction

  logic                   is_digit;
  logic [3:0]             digit_val;
  logic                   hex_ok;
  logic [3:0]             hex_val;
  logic [OFFSET_BITS+3:0] start_step, end_step;

  always_comb begin
    is_digit  = item_byte inside {[CH_0:CH_9]};
    digit_val = 4'(item_byte - CH_0);
    hex_ok    = 1'b1;
    hex_val   = 4'd0;
    if (is_digit) begin
      hex_val = digit_val;
    end else if (item_byte inside {[CH_LA:CH_LF]}) begin
      hex_val = 4'(item_byte - CH_LA + 8'd10);
    end else if (item_byte inside {[CH_UA:CH_UF]}) begin
      hex_val = 4'(item_byte - CH_UA + 8'd10);
    end else begin
      hex_ok = 1'b0;
    end
    start_step = mul10_add(start_accum, digit_val);
    end_step   = mul10_add(end_accum, digit_val);
  end

  always_comb begin
    phase_next          = phase;
    start_accum_next    = start_accum;
    end_accum_next      = end_accum;
    digit_seen_next     = digit_seen;
    previous_limit_next = previous_limit;
    have_previous_next  = have_previous;
    style_bits_next     = style_bits;
    hex_accum_next      = hex_accum;
    hex_count_next      = hex_count;
    rejected_next       = rejected;
    bytes_seen_next     = bytes_seen;
    emit                = 1'b0;
    result              = '0;

    if (!item_no_byte) begin
      bytes_seen_next = 1'b1;
      if (!rejected) begin
        if (item_byte == CH_SEMI) begin
          if (close_ok(phase, hex_count, style_bits)) begin
            previous_limit_next = end_accum;
            have_previous_next  = 1'b1;
            if (!item_last) begin
              emit   = 1'b1;
              result = make_run(STATUS_MORE, start_accum, end_accum, style_bits, hex_accum);
            end
          end else begin
            rejected_next = 1'b1;
          end
          phase_next       = PH_START;
          start_accum_next = '0;
          end_accum_next   = '0;
          digit_seen_next  = 1'b0;
          style_bits_next  = 5'd0;
          hex_accum_next   = 32'd0;
          hex_count_next   = 4'd0;
        end else begin
          case (phase)
            PH_START: begin
              if (is_digit) begin
                digit_seen_next = 1'b1;
                if (start_step[OFFSET_BITS+3:OFFSET_BITS] != 4'd0) rejected_next = 1'b1;
                else start_accum_next = start_step[OFFSET_BITS-1:0];
              end else if (item_byte == CH_DASH && digit_seen) begin
                phase_next      = PH_END;
                digit_seen_next = 1'b0;
              end else begin
                rejected_next = 1'b1;
              end
            end
            PH_END: begin
              if (is_digit) begin
                digit_seen_next = 1'b1;
                if (end_step[OFFSET_BITS+3:OFFSET_BITS] != 4'd0) rejected_next = 1'b1;
                else end_accum_next = end_step[OFFSET_BITS-1:0];
              end else if (item_byte == CH_COLON && digit_seen) begin
                if (end_accum <= start_accum) rejected_next = 1'b1;
                else if (have_previous && start_accum < previous_limit) rejected_next = 1'b1;
                else phase_next = PH_FLAGS;
              end else begin
                rejected_next = 1'b1;
              end
            end
            PH_FLAGS: begin
              if ((item_byte == CH_LB || item_byte == CH_UB) && !style_bits[SB_HAS_WEIGHT]) begin
                style_bits_next[SB_HAS_WEIGHT] = 1'b1;
                style_bits_next[SB_BOLD]       = (item_byte == CH_LB);
              end else if ((item_byte == CH_LI || item_byte == CH_UI)
                           && !style_bits[SB_HAS_SLANT]) begin
                style_bits_next[SB_HAS_SLANT] = 1'b1;
                style_bits_next[SB_ITALIC]    = (item_byte == CH_LI);
              end else if (item_byte == CH_LC) begin
                phase_next = PH_HASH;
              end else begin
                rejected_next = 1'b1;
              end
            end
            PH_HASH: begin
              if (item_byte == CH_HASH) phase_next = PH_HEX;
              else rejected_next = 1'b1;
            end
            default: begin
              if (!hex_ok || hex_count >= 4'(HEX_DIGITS)) begin
                rejected_next = 1'b1;
              end else begin
                hex_accum_next = {hex_accum[27:0], hex_val};
                hex_count_next = hex_count + 4'd1;
                if (hex_count == 4'(HEX_DIGITS - 1)) style_bits_next[SB_HAS_COLOR] = 1'b1;
              end
            end
          endcase
        end
      end
    end

    if (item_last) begin
      emit = 1'b1;
      if (!bytes_seen_next) begin
        result        = '0;
        result.status = STATUS_ACCEPTED;
      end else if (!rejected_next && close_ok(phase_next, hex_count_next, style_bits_next)) begin
        result = make_run(STATUS_ACCEPTED, start_accum_next, end_accum_next,
                          style_bits_next, hex_accum_next);
      end else begin
        result        = '0;
        result.status = STATUS_REJECTED;
      end
      // attribute done: back to the idle state for the next one
      phase_next          = PH_START;
      start_accum_next    = '0;
      end_accum_next      = '0;
      digit_seen_next     = 1'b0;
      previous_limit_next = '0;
      have_previous_next  = 1'b0;
      style_bits_next     = 5'd0;
      hex_accum_next      = 32'd0;
      hex_count_next      = 4'd0;
      rejected_next       = 1'b0;
      bytes_seen_next     = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_START;
      start_accum    <= '0;
      end_accum      <= '0;
      digit_seen     <= 1'b0;
      previous_limit <= '0;
      have_previous  <= 1'b0;
      style_bits     <= 5'd0;
      hex_accum      <= 32'd0;
      hex_count      <= 4'd0;
      rejected       <= 1'b0;
      bytes_seen     <= 1'b0;
    end else if (take) begin
      phase          <= phase_next;
      start_accum    <= start_accum_next;
      end_accum      <= end_accum_next;
      digit_seen     <= digit_seen_next;
      previous_limit <= previous_limit_next;
      have_previous  <= have_previous_next;
      style_bits     <= style_bits_next;
      hex_accum      <= hex_accum_next;
      hex_count      <= hex_count_next;
      rejected       <= rejected_next;
      bytes_seen     <= bytes_seen_next;
    end
  end

endmodule

/* hdl/style_run_list_parser_unit.sv */
// Style run list parser: input register, step logic, output register.
// A request is held in the input register, its result then in the output register.
// Throughput: one byte per cycle but for output stalls; the parser state updates once per byte.
// A byte that produces no result is retired even while the output register is stalled.
// rst (synchronous, active high) empties both registers and returns the parser to
// the start of an attribute with no previous run.
module style_run_list_parser_unit #(
  parameter int OFFSET_BITS = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,   // [7:0] in_byte
  input  logic [0:0]   s_tuser,   // [0] no_byte
  input  logic         s_tlast,   // last_of_attribute
  output logic         m_tvalid,
  input  logic         m_tready,
  // [31:0] run_first, [63:32] run_limit, [64] has_weight, [65] weight_bold,
  // [66] has_slant, [67] slant_italic, [68] has_color, [100:69] color_argb, rest zero
  output logic [103:0] m_tdata,
  output logic [2:0]   m_tuser    // [1:0] status, [2] run_valid
);
  import srlp_pkg::*;

  logic         in_valid_q;
  logic [7:0]   in_byte_q;
  logic         in_no_byte_q;
  logic         in_last_q;
  logic         out_valid_q;
  srlp_result_t out_q;
  srlp_result_t step_result;
  logic         step_emit;
  logic         take;

  srlp_core #(.OFFSET_BITS(OFFSET_BITS)) u_core (
    .clk          (clk),
    .rst          (rst),
    .item_byte    (in_byte_q),
    .item_no_byte (in_no_byte_q),
    .item_last    (in_last_q),
    .take         (take),
    .emit         (step_emit),
    .result       (step_result)
  );

  assign take     = in_valid_q && (!out_valid_q || m_tready || !step_emit);
  assign s_tready = !in_valid_q || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_tready) in_valid_q <= s_tvalid;
      if (take && step_emit) out_valid_q <= 1'b1;
      else if (m_tready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte_q    <= s_tdata;
      in_no_byte_q <= s_tuser[0];
      in_last_q    <= s_tlast;
    end
    if (take && step_emit) out_q <= step_result;
  end

  assign m_tvalid = out_valid_q;
  assign m_tuser  = {out_q.run_valid, out_q.status};
  assign m_tdata  = {3'd0, out_q.color_argb, out_q.has_color, out_q.slant_italic,
                     out_q.has_slant, out_q.weight_bold, out_q.has_weight,
                     out_q.run_limit, out_q.run_first};

endmodule
